// File: rtl/core/rbf_pkg.sv
// Package for the rectangle blit and fill engine: sizes, codes, payload
// and configuration types shared by the interface, engine and top-level files.
// No dependencies.
package rbf_pkg;

  localparam int MAX_PIXELS   = 4096;
  localparam int PALETTE_SIZE = 256;
  localparam int MAX_DIM      = 256;

  localparam int PIX_W  = 32;
  localparam int IDX_W  = 8;
  localparam int DIM_W  = 9;
  localparam int PIX_AW = $clog2(MAX_PIXELS);
  localparam int PAL_AW = $clog2(PALETTE_SIZE);
  localparam int ROW_W  = 2 * DIM_W;
  localparam int CHK_W  = 2 * DIM_W + 3;

  typedef enum logic [2:0] {
    CMD_WR_PIX = 3'd0,
    CMD_RD_PIX = 3'd1,
    CMD_WR_PAL = 3'd2,
    CMD_BLIT   = 3'd3,
    CMD_FILL   = 3'd4
  } rbf_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_NOCOLOR = 2'd2
  } rbf_status_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_PIXEL_MODE = 3'd4,
    REG_PAL_COUNT  = 3'd5
  } rbf_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHK_A, S_CHK_B, S_SRCH_RD, S_SRCH_CMP,
    S_RUN, S_DRAIN, S_RD_WAIT, S_FIN
  } rbf_state_t;

  typedef struct packed {
    rbf_cmd_t         cmd;
    logic             surface_sel;
    logic [11:0]      address;
    logic [PIX_W-1:0] write_data;
    logic [7:0]       src_x;
    logic [7:0]       src_y;
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [7:0]       dst_x;
    logic [7:0]       dst_y;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } rbf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    rbf_status_t      status;
  } rbf_out_t;

  // Effective configuration as seen by the engine
  typedef struct packed {
    logic [DIM_W-1:0]  src_w;
    logic [DIM_W-1:0]  src_h;
    logic [DIM_W-1:0]  dst_w;
    logic [DIM_W-1:0]  dst_h;
    logic              mode32;
    logic [PAL_AW:0]   pal_n;
  } rbf_cfg_t;

  // Surface size register: zero acts as one, large values clamp to MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

endpackage

// File: rtl/core/rbf_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on rbf_pkg.
interface rbf_in_if;
  logic             valid;
  logic             ready;
  rbf_pkg::rbf_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rbf_out_if;
  logic              valid;
  logic              ready;
  rbf_pkg::rbf_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/rbf_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module rbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/rbf_engine.sv
// Command sequencer for the blit and fill engine: owns the surface and
// palette memories and walks rectangles one pixel per cycle.
// Depends on rbf_pkg, rbf_if and rbf_ram.
module rbf_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  rbf_pkg::rbf_cfg_t cfg,
  rbf_in_if.sink            in_ch,
  rbf_out_if.source         out_ch
);
  import rbf_pkg::*;

  rbf_state_t       state_r, state_nxt;
  rbf_in_t          req_r;
  logic [DIM_W-1:0] w_r, w_nxt, h_r, h_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [ROW_W-1:0] srow_r, srow_nxt, drow_r, drow_nxt;
  rbf_status_t      st_r, st_nxt;
  logic [PIX_W-1:0] rd_r, rd_nxt, val_r, val_nxt;
  logic [PAL_AW:0]  idx_r, idx_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [PIX_AW-1:0] p_addr_r, p_addr_nxt;
  logic             out_vld_r, out_vld_nxt;
  rbf_out_t         out_r, out_nxt;
  logic [PALETTE_SIZE-1:0] pal_vld_r;

  // Memory ports
  logic              src_we, dst_we, pal_we;
  logic [PIX_AW-1:0] src_waddr, src_raddr, dst_waddr, dst_raddr;
  logic [PIX_W-1:0]  src_wdata, src_rdata, dst_wdata, dst_rdata, pal_wdata, pal_rdata;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;

  // Working values
  logic [PIX_W-1:0] mask;
  logic [DIM_W-1:0] sw0, sh0, dw0, dh0;
  logic [ROW_W-1:0] area, s_lin, d_lin;
  logic [PIX_W-1:0] pal_q;
  logic             last_col, last_row;

  rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_src_ram (
    .clk(clk), .we(src_we), .waddr(src_waddr), .wdata(src_wdata),
    .raddr(src_raddr), .rdata(src_rdata)
  );

  rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_dst_ram (
    .clk(clk), .we(dst_we), .waddr(dst_waddr), .wdata(dst_wdata),
    .raddr(dst_raddr), .rdata(dst_rdata)
  );

  rbf_ram #(.WIDTH(PIX_W), .DEPTH(PALETTE_SIZE)) u_pal_ram (
    .clk(clk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(pal_raddr), .rdata(pal_rdata)
  );

  // Rectangle lies inside the surface and below the memory size
  function automatic logic rect_ok(input logic [7:0] x, input logic [7:0] y,
                                   input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                   input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh);
    logic [DIM_W:0] xe, ye;
    logic [CHK_W-1:0] last;
    xe = {2'b00, x} + {1'b0, w};
    ye = {2'b00, y} + {1'b0, h};
    last = CHK_W'(ye - 10'd1) * CHK_W'(sw) + CHK_W'(xe - 10'd1);
    return (xe <= {1'b0, sw}) && (ye <= {1'b0, sh}) && (last < CHK_W'(MAX_PIXELS));
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  assign mask  = cfg.mode32 ? '1 : PIX_W'({IDX_W{1'b1}});
  assign sw0   = (req_r.src_w == '0) ? cfg.src_w : req_r.src_w;
  assign sh0   = (req_r.src_h == '0) ? cfg.src_h : req_r.src_h;
  assign dw0   = (req_r.dst_w == '0) ? cfg.dst_w : req_r.dst_w;
  assign dh0   = (req_r.dst_h == '0) ? cfg.dst_h : req_r.dst_h;
  assign area  = req_r.surface_sel ? ROW_W'(cfg.dst_w * cfg.dst_h)
                                   : ROW_W'(cfg.src_w * cfg.src_h);
  assign s_lin = srow_r + ROW_W'(req_r.src_x) + ROW_W'(i_r);
  assign d_lin = drow_r + ROW_W'(req_r.dst_x) + ROW_W'(i_r);
  assign pal_q = pal_vld_r[idx_r[PAL_AW-1:0]] ? pal_rdata : '0;
  assign last_col = (i_r == w_r - DIM_W'(1));
  assign last_row = (j_r == h_r - DIM_W'(1));

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      pal_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (pal_we) pal_vld_r[pal_waddr] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    w_r <= w_nxt;  h_r <= h_nxt;  i_r <= i_nxt;  j_r <= j_nxt;
    srow_r <= srow_nxt;  drow_r <= drow_nxt;
    st_r <= st_nxt;  rd_r <= rd_nxt;  val_r <= val_nxt;  idx_r <= idx_nxt;
    p_addr_r <= p_addr_nxt;  out_r <= out_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    w_nxt = w_r;  h_nxt = h_r;  i_nxt = i_r;  j_nxt = j_r;
    srow_nxt = srow_r;  drow_nxt = drow_r;
    st_nxt = st_r;  rd_nxt = rd_r;  val_nxt = val_r;  idx_nxt = idx_r;
    p_vld_nxt  = 1'b0;
    p_addr_nxt = PIX_AW'(d_lin);
    out_nxt    = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;

    src_we = 1'b0;  src_waddr = PIX_AW'(req_r.address);
    src_wdata = req_r.write_data & mask;  src_raddr = PIX_AW'(req_r.address);
    dst_we = 1'b0;  dst_waddr = PIX_AW'(req_r.address);
    dst_wdata = req_r.write_data & mask;  dst_raddr = PIX_AW'(req_r.address);
    pal_we = 1'b0;  pal_waddr = req_r.address[PAL_AW-1:0];
    pal_wdata = req_r.write_data;  pal_raddr = idx_r[PAL_AW-1:0];

    // Pending blit write from the previous cycle's source read
    if (p_vld_r) begin
      dst_we    = 1'b1;
      dst_waddr = p_addr_r;
      dst_wdata = src_rdata & mask;
    end

    unique case (state_r)
      S_IDLE: begin
        st_nxt = ST_OK;
        rd_nxt = '0;
        if (in_ch.valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        i_nxt = '0;
        j_nxt = '0;
        state_nxt = S_FIN;
        case (req_r.cmd)
          CMD_WR_PIX, CMD_RD_PIX: begin
            if (ROW_W'(req_r.address) >= area ||
                ROW_W'(req_r.address) >= ROW_W'(MAX_PIXELS)) begin
              st_nxt = ST_BOUNDS;
            end else if (req_r.cmd == CMD_WR_PIX) begin
              src_we = !req_r.surface_sel;
              dst_we = req_r.surface_sel;
            end else begin
              state_nxt = S_RD_WAIT;
            end
          end
          CMD_WR_PAL: begin
            if (req_r.address >= 12'(PALETTE_SIZE)) st_nxt = ST_BOUNDS;
            else pal_we = 1'b1;
          end
          CMD_BLIT: begin
            w_nxt = (sw0 > dw0) ? dw0 : sw0;
            h_nxt = (sh0 > dh0) ? dh0 : sh0;
            state_nxt = S_CHK_A;
          end
          CMD_FILL: begin
            w_nxt = dw0;
            h_nxt = dh0;
            state_nxt = S_CHK_B;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_CHK_A: begin
        srow_nxt = ROW_W'(req_r.src_y * cfg.src_w);
        if (!rect_ok(req_r.src_x, req_r.src_y, w_r, h_r, cfg.src_w, cfg.src_h)) begin
          st_nxt = ST_BOUNDS;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK_B;
        end
      end
      S_CHK_B: begin
        drow_nxt = ROW_W'(req_r.dst_y * cfg.dst_w);
        val_nxt  = req_r.write_data;
        idx_nxt  = '0;
        if (!rect_ok(req_r.dst_x, req_r.dst_y, w_r, h_r, cfg.dst_w, cfg.dst_h)) begin
          st_nxt = ST_BOUNDS;
          state_nxt = S_FIN;
        end else if (req_r.cmd == CMD_FILL && !cfg.mode32) begin
          if (cfg.pal_n == '0) begin
            val_nxt = '0;
            st_nxt = ST_NOCOLOR;
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (pal_q == req_r.write_data) begin
          val_nxt = PIX_W'(idx_r[PAL_AW-1:0]) & PIX_W'({IDX_W{1'b1}});
          state_nxt = S_RUN;
        end else if (idx_r + 1'b1 == cfg.pal_n) begin
          val_nxt = '0;
          st_nxt = ST_NOCOLOR;
          state_nxt = S_RUN;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_RUN: begin
        if (req_r.cmd == CMD_BLIT) begin
          src_raddr = PIX_AW'(s_lin);
          p_vld_nxt = 1'b1;
        end else begin
          dst_we    = 1'b1;
          dst_waddr = PIX_AW'(d_lin);
          dst_wdata = val_r;
        end
        // Raster walk over the rectangle
        if (last_col) begin
          i_nxt    = '0;
          j_nxt    = j_r + 1'b1;
          srow_nxt = srow_r + ROW_W'(cfg.src_w);
          drow_nxt = drow_r + ROW_W'(cfg.dst_w);
          if (last_row) state_nxt = (req_r.cmd == CMD_BLIT) ? S_DRAIN : S_FIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_RD_WAIT: begin
        rd_nxt = (req_r.surface_sel ? dst_rdata : src_rdata) & mask;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_nxt.read_data = rd_r;
          out_nxt.status = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/rect_blit_and_fill_engine_core.sv
// Top level of the rectangle blit and fill engine: configuration registers
// and the command sequencer.
// Depends on rbf_pkg, rbf_if and rbf_engine.
//
// Usage: requests arrive on in_ch (valid/ready), one result per request
// leaves on out_ch. Configuration is written through cfg_we/cfg_index/
// cfg_wdata while the block is idle; it takes effect at once.
// Writes pass S_PREP and S_FIN; pixel reads add S_RD_WAIT. A blit runs
// S_CHK_A, S_CHK_B, S_RUN over w*h pixels, S_DRAIN and S_FIN; a fill skips
// S_CHK_A and S_DRAIN; an 8-bit fill adds S_SRCH_RD and S_SRCH_CMP per
// palette entry searched. Throughput is set by the single surface memory
// write port: one rectangle pixel per cycle. Bounds failures skip S_RUN.
// One request is worked on at a time; the next one is accepted while the
// previous result still waits in the output register. If the receiver
// stalls, the finished request holds in its last step until the output
// register frees. Reset clears control state, the palette (through valid
// bits) and the configuration to 64x64 surfaces, 32-bit pixels and 256
// palette entries; surface memories are not cleared.
module rect_blit_and_fill_engine_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [rbf_pkg::DIM_W-1:0] cfg_wdata,
  rbf_in_if.sink                    in_ch,
  rbf_out_if.source                 out_ch
);
  import rbf_pkg::*;

  logic [DIM_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [DIM_W-1:0] pal_count_r;
  logic             pixel_mode_r;
  rbf_cfg_t         cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(64);
      src_height_r <= DIM_W'(64);
      dst_width_r  <= DIM_W'(64);
      dst_height_r <= DIM_W'(64);
      pixel_mode_r <= 1'b1;
      pal_count_r  <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (rbf_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        REG_DST_WIDTH:  dst_width_r  <= cfg_wdata;
        REG_DST_HEIGHT: dst_height_r <= cfg_wdata;
        REG_PIXEL_MODE: pixel_mode_r <= cfg_wdata[0];
        REG_PAL_COUNT:  pal_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective sizes
  assign cfg.src_w  = eff_dim(src_width_r);
  assign cfg.src_h  = eff_dim(src_height_r);
  assign cfg.dst_w  = eff_dim(dst_width_r);
  assign cfg.dst_h  = eff_dim(dst_height_r);
  assign cfg.mode32 = pixel_mode_r;
  assign cfg.pal_n  = (pal_count_r > DIM_W'(PALETTE_SIZE)) ? (PAL_AW+1)'(PALETTE_SIZE)
                                                           : (PAL_AW+1)'(pal_count_r);

  rbf_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );

`ifndef NO_ASSERTIONS
  // Sequential block: busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while busy");

  // Status code is always a defined one
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.status == ST_OK || out_ch.data.status == ST_BOUNDS ||
                      out_ch.data.status == ST_NOCOLOR))
    else $error("undefined status code");

  // Read data is only carried by successful requests
  a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.read_data != '0 |-> out_ch.data.status == ST_OK)
    else $error("read data on failed request");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for rect_blit_and_fill_engine_core: random pixel,
// palette, blit and fill requests checked against a behavioral surface model.
// Depends on rbf_pkg, rbf_if and the core RTL.
`timescale 1ns / 1ps

import rbf_pkg::*;

// Behavioral copy of the engine: surfaces, palette, registers and expected results
class blit_scoreboard;
  logic [31:0] src_mem [MAX_PIXELS];
  logic [31:0] dst_mem [MAX_PIXELS];
  logic [31:0] pal_mem [PALETTE_SIZE];
  bit          src_set [MAX_PIXELS];
  logic [8:0]  reg_src_w, reg_src_h, reg_dst_w, reg_dst_h, reg_pal_n;
  logic        reg_mode32;
  rbf_out_t    expected_results[$];
  int          errors;

  function new();
    reg_src_w = 9'd64; reg_src_h = 9'd64;
    reg_dst_w = 9'd64; reg_dst_h = 9'd64;
    reg_mode32 = 1'b1; reg_pal_n = 9'd256;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (src_set[i]) src_set[i] = 1'b0;
    errors = 0;
  endfunction

  function int unsigned clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function bit rect_fits(int unsigned x, y, w, h, sw, sh);
    if (x + w > sw || y + h > sh) return 0;
    return (y + h - 1) * sw + (x + w - 1) < MAX_PIXELS;
  endfunction

  function void write_reg(rbf_reg_t idx, logic [8:0] v);
    case (idx)
      REG_SRC_WIDTH:  reg_src_w = v;
      REG_SRC_HEIGHT: reg_src_h = v;
      REG_DST_WIDTH:  reg_dst_w = v;
      REG_DST_HEIGHT: reg_dst_h = v;
      REG_PIXEL_MODE: reg_mode32 = v[0];
      REG_PAL_COUNT:  reg_pal_n = v;
      default: ;
    endcase
  endfunction

  // A request that would read a never-written source pixel becomes a write of it
  function rbf_in_t steer_request(rbf_in_t r);
    int unsigned sw_e, sh_e, dw_e, dh_e, w, h, dw, dh, si;
    rbf_in_t g;
    g = r;
    sw_e = clamp_dim(reg_src_w); sh_e = clamp_dim(reg_src_h);
    dw_e = clamp_dim(reg_dst_w); dh_e = clamp_dim(reg_dst_h);
    if (r.cmd == CMD_RD_PIX && !r.surface_sel) begin
      if (r.address < sw_e * sh_e && !src_set[r.address]) g.cmd = CMD_WR_PIX;
    end else if (r.cmd == CMD_BLIT) begin
      dw = r.dst_w == 0 ? dw_e : r.dst_w;
      dh = r.dst_h == 0 ? dh_e : r.dst_h;
      w = r.src_w == 0 ? sw_e : r.src_w;
      h = r.src_h == 0 ? sh_e : r.src_h;
      if (w > dw) w = dw;
      if (h > dh) h = dh;
      if (rect_fits(r.src_x, r.src_y, w, h, sw_e, sh_e) &&
          rect_fits(r.dst_x, r.dst_y, w, h, dw_e, dh_e))
        for (int j = 0; j < h; j++)
          for (int i = 0; i < w; i++) begin
            si = (r.src_y + j) * sw_e + r.src_x + i;
            if (si < MAX_PIXELS && !src_set[si]) begin
              g.cmd = CMD_WR_PIX;
              g.surface_sel = 1'b0;
              g.address = si[11:0];
              return g;
            end
          end
    end
    return g;
  endfunction

  // Predict the result of one accepted request and update the model state
  function void note_request(rbf_in_t r);
    int unsigned sw_e, sh_e, dw_e, dh_e, w, h, area, si, di, n;
    logic [31:0] mask, color;
    rbf_out_t res;
    bit found;
    sw_e = clamp_dim(reg_src_w); sh_e = clamp_dim(reg_src_h);
    dw_e = clamp_dim(reg_dst_w); dh_e = clamp_dim(reg_dst_h);
    mask = reg_mode32 ? 32'hFFFF_FFFF : 32'h0000_00FF;
    res.read_data = '0;
    res.status = ST_OK;
    case (r.cmd)
      CMD_WR_PIX, CMD_RD_PIX: begin
        area = r.surface_sel ? dw_e * dh_e : sw_e * sh_e;
        if (r.address >= area || r.address >= MAX_PIXELS) res.status = ST_BOUNDS;
        else if (r.cmd == CMD_WR_PIX) begin
          if (r.surface_sel) dst_mem[r.address] = r.write_data & mask;
          else begin
            src_mem[r.address] = r.write_data & mask;
            src_set[r.address] = 1'b1;
          end
        end else
          res.read_data = (r.surface_sel ? dst_mem[r.address] : src_mem[r.address]) & mask;
      end
      CMD_WR_PAL: begin
        if (r.address >= PALETTE_SIZE) res.status = ST_BOUNDS;
        else pal_mem[r.address] = r.write_data;
      end
      CMD_BLIT: begin
        w = r.src_w == 0 ? sw_e : r.src_w;
        h = r.src_h == 0 ? sh_e : r.src_h;
        if (h > (r.dst_h == 0 ? dh_e : r.dst_h)) h = r.dst_h == 0 ? dh_e : r.dst_h;
        if (w > (r.dst_w == 0 ? dw_e : r.dst_w)) w = r.dst_w == 0 ? dw_e : r.dst_w;
        if (!rect_fits(r.src_x, r.src_y, w, h, sw_e, sh_e) ||
            !rect_fits(r.dst_x, r.dst_y, w, h, dw_e, dh_e))
          res.status = ST_BOUNDS;
        else
          for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) begin
              si = (r.src_y + j) * sw_e + r.src_x + i;
              di = (r.dst_y + j) * dw_e + r.dst_x + i;
              if (si < MAX_PIXELS && di < MAX_PIXELS) dst_mem[di] = src_mem[si] & mask;
            end
      end
      CMD_FILL: begin
        w = r.dst_w == 0 ? dw_e : r.dst_w;
        h = r.dst_h == 0 ? dh_e : r.dst_h;
        color = r.write_data;
        if (!rect_fits(r.dst_x, r.dst_y, w, h, dw_e, dh_e)) res.status = ST_BOUNDS;
        else begin
          if (!reg_mode32) begin
            n = reg_pal_n > PALETTE_SIZE ? PALETTE_SIZE : reg_pal_n;
            color = '0;
            found = 0;
            for (int i = 0; i < n && !found; i++)
              if (pal_mem[i] == r.write_data) begin
                color = i & 8'hFF;
                found = 1;
              end
            if (!found) res.status = ST_NOCOLOR;
          end
          for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) begin
              di = (r.dst_y + j) * dw_e + r.dst_x + i;
              if (di < MAX_PIXELS) dst_mem[di] = color;
            end
        end
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task check_result(rbf_out_t got);
    rbf_out_t want;
    if (expected_results.size() == 0) begin
      report("result with no request outstanding");
      return;
    end
    want = expected_results.pop_front();
    if (got.read_data !== want.read_data)
      report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
  endtask
endclass

module testbench;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  rbf_in_if  in_ch();
  rbf_out_if out_ch();

  rect_blit_and_fill_engine_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  blit_scoreboard sb = new();
  int hold_req = 0;
  int idle_count = 0;
  int burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall pattern is redrawn periodically from four stall rates; long hold on request
  initial begin
    int hold_left, cyc, stall_pct;
    hold_left = 0; cyc = 0; stall_pct = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitors and watchdog
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_count = 0;
    else if (++idle_count >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task send_request(rbf_in_t r);
    int gap;
    r = sb.steer_request(r);
    in_ch.data <= r;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    // Bursts of random length, random gaps between them
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_reg(rbf_reg_t idx, logic [DIM_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  function automatic rbf_in_t blank_request(rbf_cmd_t c);
    rbf_in_t r;
    r = '0;
    r.cmd = c;
    return r;
  endfunction

  function automatic logic [8:0] rand_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return 9'($urandom_range(1, 6));
    if (p < 92) return '0;
    return 9'($urandom_range(0, 256));
  endfunction

  function automatic logic [7:0] rand_coord(int unsigned dim);
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, dim - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rbf_in_t random_request();
    rbf_in_t r;
    int p;
    int unsigned area;
    r.cmd = CMD_WR_PIX;
    r.surface_sel = 1'($urandom_range(0, 1));
    r.write_data = $urandom();
    r.src_w = rand_size(); r.src_h = rand_size();
    r.dst_w = rand_size(); r.dst_h = rand_size();
    r.src_x = rand_coord(sb.clamp_dim(sb.reg_src_w));
    r.src_y = rand_coord(sb.clamp_dim(sb.reg_src_h));
    r.dst_x = rand_coord(sb.clamp_dim(sb.reg_dst_w));
    r.dst_y = rand_coord(sb.clamp_dim(sb.reg_dst_h));
    area = r.surface_sel ? sb.clamp_dim(sb.reg_dst_w) * sb.clamp_dim(sb.reg_dst_h)
                         : sb.clamp_dim(sb.reg_src_w) * sb.clamp_dim(sb.reg_src_h);
    if (area > MAX_PIXELS) area = MAX_PIXELS;
    r.address = $urandom_range(0, 4) != 0 ? 12'($urandom_range(0, area - 1))
                                          : 12'($urandom_range(0, 4095));
    p = $urandom_range(0, 99);
    if (p < 20) r.cmd = CMD_WR_PIX;
    else if (p < 45) r.cmd = CMD_RD_PIX;
    else if (p < 55) begin
      r.cmd = CMD_WR_PAL;
      if ($urandom_range(0, 4) != 0) r.address = 12'($urandom_range(0, 15));
    end else if (p < 75) r.cmd = CMD_BLIT;
    else if (p < 95) begin
      r.cmd = CMD_FILL;
      if ($urandom_range(0, 1)) r.write_data = sb.pal_mem[$urandom_range(0, 20)];
    end else r.cmd = rbf_cmd_t'($urandom_range(5, 7));
    return r;
  endfunction

  initial begin
    rbf_in_t r;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Whole destination filled up front; source pixels get written on first touch
    r = blank_request(CMD_FILL);
    r.write_data = $urandom();
    send_request(r);

    // Directed: field extremes, every command, special cases
    r = blank_request(CMD_WR_PIX); r.address = 12'hFFF; r.write_data = '1;
    send_request(r);
    r.surface_sel = 1'b1; r.write_data = '0; send_request(r);
    r = blank_request(CMD_RD_PIX); r.address = 12'hFFF; send_request(r);
    r.surface_sel = 1'b1; send_request(r);
    r = blank_request(CMD_WR_PAL); r.address = 12'd255; r.write_data = '1; send_request(r);
    r.address = 12'd256; send_request(r);
    r.address = 12'hFFF; send_request(r);
    r = blank_request(CMD_BLIT); send_request(r);
    r.src_x = 8'd63; r.src_y = 8'd63; r.src_w = 9'd1; r.src_h = 9'd1;
    r.dst_x = 8'd255; r.dst_y = 8'd255; send_request(r);
    r = blank_request(CMD_BLIT); r.src_w = 9'd256; r.src_h = 9'd256;
    r.dst_w = 9'd3; r.dst_h = 9'd2; send_request(r);
    r = blank_request(CMD_FILL); r.dst_x = 8'd60; r.dst_w = 9'd5; r.dst_h = 9'd1;
    send_request(r);
    r.dst_x = 8'd59; r.write_data = 32'hA5A5_5A5A; send_request(r);
    for (int c = 5; c < 8; c++) begin
      r = random_request(); r.cmd = rbf_cmd_t'(c); send_request(r);
    end
    wait_drained();

    // Phases over register settings; extremes first, then random ones
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SRC_WIDTH, 9'd0); write_reg(REG_SRC_HEIGHT, 9'd0);
          write_reg(REG_DST_WIDTH, 9'd0); write_reg(REG_DST_HEIGHT, 9'd0);
          write_reg(REG_PIXEL_MODE, 9'd0); write_reg(REG_PAL_COUNT, 9'd0);
        end
        1: begin
          write_reg(REG_SRC_WIDTH, 9'd256); write_reg(REG_SRC_HEIGHT, 9'd16);
          write_reg(REG_DST_WIDTH, 9'd256); write_reg(REG_DST_HEIGHT, 9'd16);
          write_reg(REG_PIXEL_MODE, 9'd0); write_reg(REG_PAL_COUNT, 9'd256);
        end
        2: begin
          write_reg(REG_SRC_WIDTH, 9'h1FF); write_reg(REG_SRC_HEIGHT, 9'h1FF);
          write_reg(REG_DST_WIDTH, 9'h1FF); write_reg(REG_DST_HEIGHT, 9'd1);
          write_reg(REG_PIXEL_MODE, 9'h1FF); write_reg(REG_PAL_COUNT, 9'h1FF);
        end
        default: begin
          write_reg(REG_SRC_WIDTH, 9'($urandom_range(0, 7) == 0 ? $urandom_range(0, 511)
                                                                : $urandom_range(1, 80)));
          write_reg(REG_SRC_HEIGHT, 9'($urandom_range(1, 80)));
          write_reg(REG_DST_WIDTH, 9'($urandom_range(1, 80)));
          write_reg(REG_DST_HEIGHT, 9'($urandom_range(0, 7) == 0 ? $urandom_range(0, 511)
                                                                 : $urandom_range(1, 80)));
          write_reg(REG_PIXEL_MODE, 9'($urandom_range(0, 1)));
          write_reg(REG_PAL_COUNT, 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                                : $urandom_range(1, 24)));
        end
      endcase
      // One phase runs back to back into a long receiver hold
      if (ph == 4) begin
        hold_req = 1;
        for (int k = 0; k < 20; k++) begin
          r = sb.steer_request(random_request());
          in_ch.data <= r;
          in_ch.valid <= 1'b1;
          do @(posedge clk); while (!in_ch.ready);
          @(negedge clk);
        end
      end
      for (int k = 0; k < 125; k++) send_request(random_request());
      wait_drained();
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/rbf_pkg.sv
rtl/core/rbf_if.sv
rtl/core/rbf_ram.sv
rtl/core/rbf_engine.sv
rtl/core/rect_blit_and_fill_engine_core.sv
verif/testbench.sv
